>>> rtl/core/ste_pkg.sv
`timescale 1ns / 1ps

package ste_pkg;

    localparam int TIME_BITS           = 26;
    localparam int INDEX_BITS          = 11;
    localparam int ROM_DEPTH           = 1 << INDEX_BITS;
    localparam int FREQ_BITS           = 33;
    localparam int HALF_DIM_DEF        = 2048;
    localparam int OUT_BITS_DEF        = 16;
    localparam int TIME_FRAC_BITS_DEF  = 16;
    localparam int TIME_LIMIT_INT      = 1000;

    // round(2^32 / (2*pi))
    localparam logic [29:0] INV_TWO_PI_Q32 = 30'h28BE60DC;
    localparam logic [30:0] Q30_ONE        = 31'h4000_0000;

    // Taylor terms of sin(pi/2 * x), Q30
    localparam int SIN_TERMS = 5;
    localparam logic [30:0] SIN_COEF [SIN_TERMS] = '{
        31'd1686629713,
        31'd693598669,
        31'd85569306,
        31'd5026995,
        31'd172272
    };

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_1,
        QUAD_2,
        QUAD_3
    } quad_t;

endpackage

>>> rtl/core/ste_in_if.sv
`timescale 1ns / 1ps

interface ste_in_if;
    import ste_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [TIME_BITS-1:0]  time_value;
    logic [INDEX_BITS-1:0] freq_index;

    modport source (output valid, time_value, freq_index, input ready);
    modport sink   (input valid, time_value, freq_index, output ready);
endinterface

>>> rtl/core/ste_out_if.sv
`timescale 1ns / 1ps

interface ste_out_if #(
    parameter int OUT_BITS = ste_pkg::OUT_BITS_DEF
);
    logic                       valid;
    logic                       ready;
    logic signed [OUT_BITS-1:0] sine_out;
    logic signed [OUT_BITS-1:0] cosine_out;
    logic                       range_error;

    modport source (output valid, sine_out, cosine_out, range_error, input ready);
    modport sink   (input valid, sine_out, cosine_out, range_error, output ready);
endinterface

>>> rtl/core/ste_freq_rom.sv
`timescale 1ns / 1ps

module ste_freq_rom #(
    parameter int HALF_DIM = ste_pkg::HALF_DIM_DEF
) (
    input  logic                           clk,
    input  logic                           en,
    input  logic [ste_pkg::INDEX_BITS-1:0] addr,
    output logic [ste_pkg::FREQ_BITS-1:0]  rd_data
);
    import ste_pkg::*;

    typedef logic [ROM_DEPTH-1:0][FREQ_BITS-1:0] rom_t;

    function automatic logic [63:0] int_sqrt(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        b = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (b > v)
                b = b >> 2;
        end
        for (int k = 0; k < 32; k++) begin
            if (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // w_i = 10000^(-i/HALF_DIM) in Q32; slots beyond the half wrap
    function automatic rom_t build_rom();
        logic [63:0] roots [32];
        logic [63:0] y;
        logic [63:0] lg;
        logic [63:0] iv;
        logic [63:0] e;
        logic [63:0] n;
        logic [63:0] f;
        logic [63:0] m;
        rom_t        tbl;
        y  = 64'd10000 << 18;
        lg = '0;
        for (int k = 0; k < 32; k++) begin
            y  = (y * y) >> 31;
            lg = lg << 1;
            if (y >= (64'd1 << 32)) begin
                lg = lg | 64'd1;
                y  = y >> 1;
            end
        end
        lg = lg | (64'd13 << 32);
        roots[0] = '0;
        roots[1] = int_sqrt(64'd1 << 61);
        for (int k = 2; k < 32; k++)
            roots[k] = int_sqrt(roots[k-1] << 31);
        for (int j = 0; j < ROM_DEPTH; j++) begin
            iv = 64'(j % HALF_DIM);
            e  = (lg * iv) / HALF_DIM;
            n  = e >> 32;
            f  = e & 64'hFFFF_FFFF;
            m  = 64'd1 << 31;
            for (int k = 1; k < 32; k++) begin
                if (f[32-k])
                    m = (m * roots[k] + (64'd1 << 30)) >> 31;
            end
            tbl[j] = (n < 64'd40) ? FREQ_BITS'((m << 1) >> n) : '0;
        end
        return tbl;
    endfunction

    localparam rom_t FREQ_TABLE = build_rom();

    logic [FREQ_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (en)
            rd_data_reg <= FREQ_TABLE[addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/sinusoidal_time_embedding.sv
// Sinusoidal timestep embedding: each item carries a timestep (unsigned,
// TIME_FRAC_BITS fraction bits) and a frequency slot i, and returns
// sin(t*w_i) and cos(t*w_i) in signed Q1.(OUT_BITS-1), w_i = 10000^(-i/HALF_DIM)
// from a frequency table fixed at elaboration. A timestep above 1000.0 gives
// zero outputs with range_error set. The block takes one item per clock unless
// a stalled output has filled every stage, and returns each result through a
// 12-stage chain of table read, phase multiply, turn reduction, the Horner
// steps of the quarter-wave sine polynomial and the quadrant fold.
// A stalled output fills empty stages first, so ready stays high until every
// stage holds an item.
`timescale 1ns / 1ps

module sinusoidal_time_embedding #(
    parameter int HALF_DIM       = ste_pkg::HALF_DIM_DEF,
    parameter int OUT_BITS       = ste_pkg::OUT_BITS_DEF,
    parameter int TIME_FRAC_BITS = ste_pkg::TIME_FRAC_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    ste_in_if.sink    din,
    ste_out_if.source dout
);
    import ste_pkg::*;

    localparam int NS        = 12;
    localparam int LOP_BITS  = TIME_BITS + 32;
    localparam int PROD_BITS = TIME_BITS + FREQ_BITS;
    localparam int A_BITS    = PROD_BITS - TIME_FRAC_BITS;
    localparam int HI_BITS   = A_BITS - 32;
    localparam int LIM_BITS  = 10 + TIME_FRAC_BITS;
    localparam int CMP_BITS  = (LIM_BITS > TIME_BITS) ? LIM_BITS : TIME_BITS;
    localparam logic [LIM_BITS-1:0] TIME_LIMIT =
        LIM_BITS'(TIME_LIMIT_INT) << TIME_FRAC_BITS;

    localparam int SH_R = (OUT_BITS <= 30) ? 31 - OUT_BITS : 0;
    localparam int SH_L = (OUT_BITS <= 30) ? 0 : OUT_BITS - 31;
    localparam logic [33:0] ROUND = (SH_R > 0) ? (34'd1 << (SH_R - 1)) : 34'd0;
    localparam logic [33:0] MAXV  = (34'd1 << (OUT_BITS - 1)) - 34'd1;
    localparam logic [OUT_BITS-1:0] MOST_NEG = OUT_BITS'(1) << (OUT_BITS - 1);

    function automatic logic [OUT_BITS-1:0] to_output(input logic [31:0] s,
                                                      input logic neg);
        logic [33:0] v;
        v = ((34'(s) + ROUND) >> SH_R) << SH_L;
        if (v > MAXV)
            v = MAXV;
        if (neg)
            v = ~v + 34'd1;
        return v[OUT_BITS-1:0];
    endfunction

    // stage valids and per-stage advance; en[k] implies en[k-1]
    logic [1:NS]   v_reg;
    logic [1:NS+1] en;

    always_comb
    begin
        en[NS+1] = dout.ready;
        for (int k = NS; k >= 1; k--)
            en[k] = !v_reg[k] || en[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v_reg <= '0;
        end
        else begin
            if (en[1])
                v_reg[1] <= din.valid;
            for (int k = 2; k <= NS; k++) begin
                if (en[k])
                    v_reg[k] <= v_reg[k-1];
            end
        end
    end

    assign din.ready = en[1];

    // stage 1: table read, range check
    logic [FREQ_BITS-1:0] w1;
    logic [TIME_BITS-1:0] t1_reg;
    logic                 err_next;
    logic                 err_reg [1:11];

    ste_freq_rom #(
        .HALF_DIM (HALF_DIM)
    ) u_rom (
        .clk     (clk),
        .en      (en[1]),
        .addr    (din.freq_index),
        .rd_data (w1)
    );

    assign err_next = CMP_BITS'(din.time_value) > CMP_BITS'(TIME_LIMIT);

    // stage 2..11 payload
    logic [LOP_BITS-1:0]   lo_prod;
    logic [LOP_BITS-1:0]   lo_prod2_reg;
    logic [TIME_BITS-1:0]  thi2_reg;
    logic [PROD_BITS-1:0]  phase_sum;
    logic [HI_BITS-1:0]    hi3_reg;
    logic [31:0]           lo3_reg;
    logic [HI_BITS+29:0]   mh_full;
    logic [61:0]           ml_full;
    logic [31:0]           mh4_reg;
    logic [29:0]           ml4_reg;
    logic [31:0]           turns;
    quad_t                 quad_reg [5:11];
    logic [30:0]           xs_reg [5:10];
    logic [30:0]           xc_reg [5:10];
    logic [61:0]           sq_s;
    logic [61:0]           sq_c;
    logic [30:0]           zs_reg [6:9];
    logic [30:0]           zc_reg [6:9];
    logic [61:0]           hp_s [7:10];
    logic [61:0]           hp_c [7:10];
    logic [30:0]           accs_reg [7:10];
    logic [30:0]           accc_reg [7:10];
    logic [61:0]           fin_s;
    logic [61:0]           fin_c;
    logic [31:0]           ss11_reg;
    logic [31:0]           sc11_reg;

    always_comb
    begin
        lo_prod   = LOP_BITS'(t1_reg) * LOP_BITS'(w1[31:0]);
        phase_sum = PROD_BITS'({thi2_reg, 32'b0}) + PROD_BITS'(lo_prod2_reg);
        mh_full   = (HI_BITS+30)'(hi3_reg) * (HI_BITS+30)'(INV_TWO_PI_Q32);
        ml_full   = 62'(lo3_reg) * 62'(INV_TWO_PI_Q32);
        turns     = mh4_reg + {2'b0, ml4_reg};
        sq_s      = 62'(xs_reg[5]) * 62'(xs_reg[5]);
        sq_c      = 62'(xc_reg[5]) * 62'(xc_reg[5]);
        hp_s[7]   = 62'(zs_reg[6]) * 62'(SIN_COEF[4]);
        hp_c[7]   = 62'(zc_reg[6]) * 62'(SIN_COEF[4]);
        for (int k = 8; k <= 10; k++) begin
            hp_s[k] = 62'(zs_reg[k-1]) * 62'(accs_reg[k-1]);
            hp_c[k] = 62'(zc_reg[k-1]) * 62'(accc_reg[k-1]);
        end
        fin_s     = 62'(xs_reg[10]) * 62'(accs_reg[10]);
        fin_c     = 62'(xc_reg[10]) * 62'(accc_reg[10]);
    end

    always_ff @(posedge clk)
    begin
        if (en[1]) begin
            t1_reg     <= din.time_value;
            err_reg[1] <= err_next;
        end
        if (en[2]) begin
            lo_prod2_reg <= lo_prod;
            thi2_reg     <= w1[32] ? t1_reg : '0;
        end
        if (en[3]) begin
            hi3_reg <= phase_sum[PROD_BITS-1:TIME_FRAC_BITS+32];
            lo3_reg <= phase_sum[TIME_FRAC_BITS+31:TIME_FRAC_BITS];
        end
        if (en[4]) begin
            mh4_reg <= mh_full[31:0];
            ml4_reg <= ml_full[61:32];
        end
        if (en[5]) begin
            quad_reg[5] <= quad_t'(turns[31:30]);
            xs_reg[5]   <= {1'b0, turns[29:0]};
            xc_reg[5]   <= Q30_ONE - {1'b0, turns[29:0]};
        end
        if (en[6]) begin
            zs_reg[6] <= sq_s[60:30];
            zc_reg[6] <= sq_c[60:30];
        end
        for (int k = 7; k <= 9; k++) begin
            if (en[k]) begin
                zs_reg[k] <= zs_reg[k-1];
                zc_reg[k] <= zc_reg[k-1];
            end
        end
        // Horner: stage k uses the coefficient of order 10-k
        for (int k = 7; k <= 10; k++) begin
            if (en[k]) begin
                accs_reg[k] <= SIN_COEF[10-k] - hp_s[k][60:30];
                accc_reg[k] <= SIN_COEF[10-k] - hp_c[k][60:30];
            end
        end
        if (en[11]) begin
            ss11_reg <= fin_s[61:30];
            sc11_reg <= fin_c[61:30];
        end
        for (int k = 6; k <= 10; k++) begin
            if (en[k]) begin
                xs_reg[k] <= xs_reg[k-1];
                xc_reg[k] <= xc_reg[k-1];
            end
        end
        for (int k = 6; k <= 11; k++) begin
            if (en[k])
                quad_reg[k] <= quad_reg[k-1];
        end
        for (int k = 2; k <= 11; k++) begin
            if (en[k])
                err_reg[k] <= err_reg[k-1];
        end
    end

    // stage 12: quadrant fold, rounding, output register
    logic [OUT_BITS-1:0] sine_next;
    logic [OUT_BITS-1:0] cosine_next;
    logic [OUT_BITS-1:0] sine_reg;
    logic [OUT_BITS-1:0] cosine_reg;
    logic                range_error_reg;

    always_comb
    begin
        case (quad_reg[11])
            QUAD_0: begin
                sine_next   = to_output(ss11_reg, 1'b0);
                cosine_next = to_output(sc11_reg, 1'b0);
            end
            QUAD_1: begin
                sine_next   = to_output(sc11_reg, 1'b0);
                cosine_next = to_output(ss11_reg, 1'b1);
            end
            QUAD_2: begin
                sine_next   = to_output(ss11_reg, 1'b1);
                cosine_next = to_output(sc11_reg, 1'b1);
            end
            default: begin
                sine_next   = to_output(sc11_reg, 1'b1);
                cosine_next = to_output(ss11_reg, 1'b0);
            end
        endcase
        if (err_reg[11]) begin
            sine_next   = '0;
            cosine_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[12]) begin
            sine_reg        <= sine_next;
            cosine_reg      <= cosine_next;
            range_error_reg <= err_reg[11];
        end
    end

    assign dout.valid       = v_reg[NS];
    assign dout.sine_out    = sine_reg;
    assign dout.cosine_out  = cosine_reg;
    assign dout.range_error = range_error_reg;

    // ready drops only with the first stage occupied
    assert property (@(posedge clk) disable iff (!rst_n)
        !din.ready |-> v_reg[1])
        else $error("input stalled with empty first stage");

    // a result waiting at the output is not overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[NS] && !dout.ready |=> v_reg[NS] && $stable(sine_reg)
                                     && $stable(cosine_reg))
        else $error("waiting result lost");

    assert property (@(posedge clk) disable iff (!rst_n)
        dout.valid && dout.range_error |-> dout.sine_out == '0
                                           && dout.cosine_out == '0)
        else $error("range error with nonzero output");

    // saturation keeps results symmetric: the most negative code never shows
    assert property (@(posedge clk) disable iff (!rst_n)
        dout.valid |-> dout.sine_out != MOST_NEG && dout.cosine_out != MOST_NEG)
        else $error("output outside symmetric range");

endmodule

>>> verif/sinusoidal_time_embedding_tb.sv
`timescale 1ns / 1ps

module sinusoidal_time_embedding_tb;
    import ste_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 24;
    localparam bit [63:0] TIME_LIMIT = 64'(TIME_LIMIT_INT) << TIME_FRAC_BITS_DEF;
    localparam bit [63:0] TIME_MAX = (64'd1 << TIME_BITS) - 1;

    typedef struct {
        logic signed [OUT_BITS_DEF-1:0] sine;
        logic signed [OUT_BITS_DEF-1:0] cosine;
        logic                           range_err;
    } embed_result_t;

    logic clk;
    logic rst_n;

    ste_in_if  din_if ();
    ste_out_if dout_if ();

    sinusoidal_time_embedding u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_if),
        .dout  (dout_if)
    );

    bit [63:0]     freq_table [HALF_DIM_DEF];
    embed_result_t pending_embeds [$];
    embed_result_t want;
    int            mismatches = 0;
    bit            src_idle_en;
    bit            snk_idle_en;
    int            hold_len;
    int            hold_id;

    always #6 clk = ~clk;

    // ---------------------------------------------------------------
    // Frequency table and phase-to-sine predictor
    // ---------------------------------------------------------------
    function automatic bit [63:0] floor_sqrt(bit [63:0] v);
        bit [63:0] r;
        bit [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic void build_freq_table();
        bit [63:0] roots [32];
        bit [63:0] y;
        bit [63:0] lg;
        bit [63:0] e;
        bit [63:0] n;
        bit [31:0] f;
        bit [63:0] m;
        y = 64'd10000 << 18;
        lg = 0;
        // log2(10000/2^13) bit by bit through repeated squaring
        for (int k = 0; k < 32; k++)
        begin
            y = (y * y) >> 31;
            lg <<= 1;
            if (y >= (64'd1 << 32))
            begin
                lg |= 1;
                y >>= 1;
            end
        end
        lg |= 64'd13 << 32;
        roots[0] = 0;
        roots[1] = floor_sqrt(64'd1 << 61);
        for (int k = 2; k < 32; k++)
            roots[k] = floor_sqrt(roots[k-1] << 31);
        for (int i = 0; i < HALF_DIM_DEF; i++)
        begin
            e = (lg * 64'(i)) / 64'(HALF_DIM_DEF);
            n = e >> 32;
            f = e[31:0];
            m = 64'd1 << 31;
            for (int k = 1; k < 32; k++)
                if (f[32-k])
                    m = (m * roots[k] + (64'd1 << 30)) >> 31;
            freq_table[i] = (n < 40) ? ((m << 1) >> n) : 64'd0;
        end
    endfunction

    // sin(pi/2 * x), x and result in Q30
    function automatic bit [63:0] quarter_wave(bit [63:0] x);
        bit [63:0] z;
        bit [63:0] acc;
        z = (x * x) >> 30;
        acc = 64'(SIN_COEF[4]);
        for (int k = 3; k >= 0; k--)
            acc = 64'(SIN_COEF[k]) - ((z * acc) >> 30);
        return (x * acc) >> 30;
    endfunction

    function automatic logic signed [OUT_BITS_DEF-1:0] to_q15(bit [63:0] s, bit neg);
        bit [63:0] v;
        v = (s + (64'd1 << 14)) >> 15;
        if (v > 64'd32767)
            v = 64'd32767;
        if (neg)
            v = ~v + 1;
        return v[OUT_BITS_DEF-1:0];
    endfunction

    function automatic embed_result_t predict_embedding(bit [63:0] t, bit [63:0] slot);
        embed_result_t res;
        bit [63:0] a;
        bit [63:0] turns;
        bit [63:0] r;
        bit [63:0] s_r;
        bit [63:0] s_c;
        res.sine = 0;
        res.cosine = 0;
        res.range_err = 1'b0;
        if (t > TIME_LIMIT)
        begin
            res.range_err = 1'b1;
            return res;
        end
        // slots wrap at the half, which is the index width
        a = (t * freq_table[slot[INDEX_BITS-1:0]]) >> TIME_FRAC_BITS_DEF;
        turns = ((a >> 32) * 64'(INV_TWO_PI_Q32)
                 + ((64'(a[31:0]) * 64'(INV_TWO_PI_Q32)) >> 32)) & 64'hFFFF_FFFF;
        r = turns & (64'(Q30_ONE) - 1);
        s_r = quarter_wave(r);
        s_c = quarter_wave(64'(Q30_ONE) - r);
        case (quad_t'(turns[31:30]))
            QUAD_0:
            begin
                res.sine = to_q15(s_r, 1'b0);
                res.cosine = to_q15(s_c, 1'b0);
            end
            QUAD_1:
            begin
                res.sine = to_q15(s_c, 1'b0);
                res.cosine = to_q15(s_r, 1'b1);
            end
            QUAD_2:
            begin
                res.sine = to_q15(s_r, 1'b1);
                res.cosine = to_q15(s_c, 1'b1);
            end
            default:
            begin
                res.sine = to_q15(s_c, 1'b1);
                res.cosine = to_q15(s_r, 1'b0);
            end
        endcase
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Driving, receiving, checking
    // ---------------------------------------------------------------
    task automatic report_mismatch(string what, int got, int exp_val);
        $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, exp_val);
        mismatches++;
    endtask

    task automatic send_slot(bit [63:0] t, bit [63:0] slot);
        int gap;
        gap = src_idle_en ? $urandom_range(0, 3) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            din_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        din_if.time_value = t[TIME_BITS-1:0];
        din_if.freq_index = slot[INDEX_BITS-1:0];
        din_if.valid = 1'b1;
        do
            @(posedge clk);
        while (!din_if.ready);
        pending_embeds = {pending_embeds, predict_embedding(t, slot)};
    endtask

    task automatic wait_drained();
        @(negedge clk);
        din_if.valid = 1'b0;
        while (pending_embeds.size() != 0)
            @(posedge clk);
    endtask

    function automatic bit [63:0] rand_time();
        case ($urandom_range(0, 9))
            0, 1:    return 64'($urandom_range(0, 262143));
            2:       return TIME_LIMIT - 8 + 64'($urandom_range(0, 16));
            9:       return 64'($urandom_range(32'(TIME_LIMIT) + 32'd1, 32'(TIME_MAX)));
            default: return 64'($urandom_range(0, 32'(TIME_LIMIT)));
        endcase
    endfunction

    // receiver: random gap per item when enabled, plus a long hold on each new request
    initial
    begin
        int gap;
        int holds_done;
        holds_done = 0;
        dout_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_id != holds_done)
            begin
                holds_done = hold_id;
                dout_if.ready = 1'b0;
                repeat (hold_len) @(negedge clk);
            end
            gap = snk_idle_en ? $urandom_range(0, 3) : 0;
            if (gap > 0)
            begin
                dout_if.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            dout_if.ready = 1'b1;
            do
                @(posedge clk);
            while (!dout_if.valid);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && dout_if.valid && dout_if.ready)
        begin
            if (pending_embeds.size() == 0)
                report_mismatch("unexpected result", 0, 0);
            else
            begin
                want = pending_embeds.pop_front();
                if (dout_if.sine_out !== want.sine)
                    report_mismatch("sine_out", int'(dout_if.sine_out), int'(want.sine));
                if (dout_if.cosine_out !== want.cosine)
                    report_mismatch("cosine_out", int'(dout_if.cosine_out),
                                    int'(want.cosine));
                if (dout_if.range_error !== want.range_err)
                    report_mismatch("range_error", int'(dout_if.range_error),
                                    int'(want.range_err));
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    initial
    begin
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready))
                idle = 0;
            else
                idle++;
        end
        $display("FAILURE");
        $finish;
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_directed();
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
        send_slot(0, 0);
        send_slot(0, HALF_DIM_DEF - 1);
        send_slot(1, 0);
        send_slot(1, HALF_DIM_DEF - 1);
        send_slot(64'd1 << TIME_FRAC_BITS_DEF, 0);
        send_slot(64'd1 << TIME_FRAC_BITS_DEF, 1);
        send_slot(TIME_LIMIT, 0);
        send_slot(TIME_LIMIT, HALF_DIM_DEF - 1);
        send_slot(TIME_LIMIT, 12'h555);
        // just past the limit: flagged, zero outputs
        send_slot(TIME_LIMIT + 1, 0);
        send_slot(TIME_MAX, HALF_DIM_DEF - 1);
        send_slot(TIME_MAX, 0);
        send_slot(64'h2AA_AAAA & TIME_MAX, 11'h2AA);
        send_slot(64'h155_5555, 11'h555);
        send_slot(64'd500 << TIME_FRAC_BITS_DEF, 1024);
        send_slot(64'd3 << (TIME_FRAC_BITS_DEF - 2), 7);
        wait_drained();
    endtask

    task automatic test_random_slots(int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 50 == 0)
            begin
                src_idle_en = $urandom_range(0, 2) != 0;
                snk_idle_en = $urandom_range(0, 2) != 0;
            end
            send_slot(rand_time(), 64'($urandom_range(0, HALF_DIM_DEF - 1)));
        end
        wait_drained();
    endtask

    task automatic test_output_hold();
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        hold_len = 80;
        hold_id++;
        for (int i = 0; i < 40; i++)
            send_slot(rand_time(), 64'($urandom_range(0, HALF_DIM_DEF - 1)));
        wait_drained();
    endtask

    task automatic test_pause_and_resume();
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
        for (int i = 0; i < 10; i++)
            send_slot(rand_time(), 64'($urandom_range(0, HALF_DIM_DEF - 1)));
        wait_drained();
        for (int i = 0; i < 10; i++)
            send_slot(rand_time(), 64'($urandom_range(0, HALF_DIM_DEF - 1)));
        wait_drained();
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        din_if.valid = 1'b0;
        din_if.time_value = '0;
        din_if.freq_index = '0;
        hold_len = 0;
        hold_id = 0;
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        build_freq_table();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_output_hold();
        test_random_slots(450);
        test_pause_and_resume();
        test_output_hold();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/ste_pkg.sv
rtl/core/ste_in_if.sv
rtl/core/ste_out_if.sv
rtl/core/ste_freq_rom.sv
rtl/core/sinusoidal_time_embedding.sv
verif/sinusoidal_time_embedding_tb.sv
